@@ hw/rtl/record_merge_sort_by_name_top_defines.svh @@
// Assertion macros shared by the record merge sorter RTL.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef RECORD_MERGE_SORT_BY_NAME_TOP_DEFINES_SVH
`define RECORD_MERGE_SORT_BY_NAME_TOP_DEFINES_SVH

// A condition that holds at every sampled edge.
`define RMSN_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define RMSN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rmsn_pkg.sv @@
// ----------------------------------------------------------------------------
// rmsn_pkg
// Types and constants shared by the record merge sorter modules.
// ----------------------------------------------------------------------------
package rmsn_pkg;

	localparam int MAX_RECORDS = 32;
	localparam int IDX_W       = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// One record: the 20-byte name in three words, then the age.
	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] mid;
		logic [31:0] lo;
		logic [7:0]  age;
	} rec_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store_we;
		logic store_wsel_in;
		idx_t store_waddr;
		idx_t store_raddr;
		logic scr_we;
		idx_t scr_waddr;
		idx_t scr_ra;
		idx_t scr_rb;
		logic take_left;
		logic out_load;
		logic out_final;
		logic out_ovf;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic less;
	} sts_t;

endpackage

@@ hw/rtl/rmsn_datapath.sv @@
// ----------------------------------------------------------------------------
// rmsn_datapath
// Record store, merge scratch buffer, name comparator and output register.
// ----------------------------------------------------------------------------
module rmsn_datapath (
	input  logic          clk,
	input  rmsn_pkg::cmd_t cmd,
	input  rmsn_pkg::rec_t in_rec,
	output rmsn_pkg::sts_t sts,
	output rmsn_pkg::rec_t out_rec,
	output logic          out_final,
	output logic          out_ovf
);
	import rmsn_pkg::*;

	rec_t store_mem [MAX_RECORDS];
	rec_t scr_mem [MAX_RECORDS];
	rec_t store_rd_q;
	rec_t scr_a_q;
	rec_t scr_b_q;
	rec_t store_wdata;
	rec_t out_rec_q;
	logic out_final_q;
	logic out_ovf_q;
	logic [159:0] key_a;
	logic [159:0] key_b;
	logic [159:0] mask;

	// Store write data comes from the input or from the merge winner.
	assign store_wdata = cmd.store_wsel_in ? in_rec : (cmd.take_left ? scr_a_q : scr_b_q);

	// Record store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.store_we) begin
			store_mem[cmd.store_waddr] <= store_wdata;
		end
		store_rd_q <= store_mem[cmd.store_raddr];
	end

	// Scratch buffer: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.scr_we) begin
			scr_mem[cmd.scr_waddr] <= store_rd_q;
		end
		scr_a_q <= scr_mem[cmd.scr_ra];
		scr_b_q <= scr_mem[cmd.scr_rb];
	end

	// Bytes after the first zero of the left name do not take part in the compare.
	assign key_a = {scr_a_q.hi, scr_a_q.mid, scr_a_q.lo};
	assign key_b = {scr_b_q.hi, scr_b_q.mid, scr_b_q.lo};

	always_comb begin
		logic seen;
		seen = 1'b0;
		mask = '0;
		for (int b = 0; b < 20; b++) begin
			mask[159-8*b -: 8] = seen ? 8'h00 : 8'hFF;
			if (key_a[159-8*b -: 8] == 8'h00) begin
				seen = 1'b1;
			end
		end
	end

	assign sts.less = (key_a & mask) < (key_b & mask);

	// Output register, loaded from the store read port.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_rec_q   <= store_rd_q;
			out_final_q <= cmd.out_final;
			out_ovf_q   <= cmd.out_ovf;
		end
	end

	assign out_rec   = out_rec_q;
	assign out_final = out_final_q;
	assign out_ovf   = out_ovf_q;

endmodule

@@ hw/rtl/rmsn_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmsn_ctrl
// Sequencer for loading, top-down merge sort and emitting of records.
// ----------------------------------------------------------------------------
`include "record_merge_sort_by_name_top_defines.svh"

module rmsn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_record,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  rmsn_pkg::sts_t sts,
	output rmsn_pkg::cmd_t cmd
);
	import rmsn_pkg::*;

	localparam int STK_D  = 2 * IDX_W + 3;
	localparam int SP_W   = $clog2(STK_D + 1);
	localparam int SPI_W  = $clog2(STK_D);

	typedef enum logic [2:0] {
		S_LOAD, S_POP, S_COPY_RD, S_COPY_WR, S_MRG_RD, S_MRG_WR, S_EMIT_RD, S_EMIT_LD
	} state_t;

	typedef struct packed {
		idx_t s;
		idx_t e;
		logic vis;
	} stk_t;

	state_t          state_q;
	stk_t            stk_q [STK_D];
	logic [SP_W-1:0] sp_q;
	cnt_t            cnt_q;
	logic            ovf_q;
	idx_t            s_q;
	idx_t            m_q;
	idx_t            e_q;
	cnt_t            i_q;
	cnt_t            j_q;
	cnt_t            k_q;
	logic            out_valid_q;

	logic [SP_W-1:0] sp_m1;
	logic [SP_W-1:0] sp_p1;
	stk_t            top;
	idx_t            mid;
	logic [IDX_W:0]  mid_sum;
	logic            room;
	cnt_t            cnt_new;
	logic            take_left;

	assign sp_m1   = sp_q - SP_W'(1);
	assign sp_p1   = sp_q + SP_W'(1);
	assign top     = stk_q[sp_m1[SPI_W-1:0]];
	assign mid_sum = {1'b0, top.s} + {1'b0, top.e};
	assign mid     = mid_sum[IDX_W:1];
	assign room    = cnt_q < CNT_W'(MAX_RECORDS);
	assign cnt_new = room ? cnt_q + CNT_W'(1) : cnt_q;
	assign take_left = (i_q <= {1'b0, m_q}) && ((j_q > {1'b0, e_q}) || sts.less);

	// Commands decoded from the state and the index registers.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_LOAD: begin
				cmd.store_we      = in_valid && room;
				cmd.store_wsel_in = 1'b1;
				cmd.store_waddr   = cnt_q[IDX_W-1:0];
			end
			S_COPY_RD: cmd.store_raddr = k_q[IDX_W-1:0];
			S_COPY_WR: begin
				cmd.scr_we    = 1'b1;
				cmd.scr_waddr = k_q[IDX_W-1:0];
			end
			S_MRG_RD: begin
				cmd.scr_ra = i_q[IDX_W-1:0];
				cmd.scr_rb = j_q[IDX_W-1:0];
			end
			S_MRG_WR: begin
				cmd.store_we    = 1'b1;
				cmd.store_waddr = k_q[IDX_W-1:0];
				cmd.take_left   = take_left;
			end
			S_EMIT_RD: cmd.store_raddr = k_q[IDX_W-1:0];
			S_EMIT_LD: begin
				cmd.out_load  = !out_valid_q;
				cmd.out_final = (k_q + CNT_W'(1)) == cnt_q;
				cmd.out_ovf   = ovf_q;
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = out_valid_q;

	// State, range stack and index registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			sp_q        <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			s_q         <= '0;
			m_q         <= '0;
			e_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			for (int n = 0; n < STK_D; n++) begin
				stk_q[n] <= '0;
			end
		end else begin
			unique case (state_q)
				// Load one record per transfer while there is room; the last one starts the sort.
				S_LOAD: begin
					if (in_valid) begin
						cnt_q <= cnt_new;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (last_record) begin
							stk_q[0] <= '{s: '0, e: IDX_W'(cnt_new - CNT_W'(1)), vis: 1'b0};
							sp_q     <= SP_W'(1);
							state_q  <= S_POP;
						end
					end
				end
				// Walk the split tree in post order.
				S_POP: begin
					if (sp_q == '0) begin
						k_q     <= '0;
						state_q <= S_EMIT_RD;
					end else if (top.s >= top.e) begin
						sp_q <= sp_m1;
					end else if (!top.vis) begin
						stk_q[sp_m1[SPI_W-1:0]].vis <= 1'b1;
						stk_q[sp_q[SPI_W-1:0]]  <= '{s: mid + IDX_W'(1), e: top.e, vis: 1'b0};
						stk_q[sp_p1[SPI_W-1:0]] <= '{s: top.s, e: mid, vis: 1'b0};
						sp_q <= sp_q + SP_W'(2);
					end else begin
						sp_q    <= sp_m1;
						s_q     <= top.s;
						m_q     <= mid;
						e_q     <= top.e;
						k_q     <= CNT_W'(top.s);
						state_q <= S_COPY_RD;
					end
				end
				S_COPY_RD: state_q <= S_COPY_WR;
				// Copy the range into scratch, then start the merge.
				S_COPY_WR: begin
					if (k_q == CNT_W'(e_q)) begin
						i_q     <= CNT_W'(s_q);
						j_q     <= CNT_W'(m_q) + CNT_W'(1);
						k_q     <= CNT_W'(s_q);
						state_q <= S_MRG_RD;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_COPY_RD;
					end
				end
				S_MRG_RD: state_q <= S_MRG_WR;
				// Equal names take the right record first.
				S_MRG_WR: begin
					if (take_left) begin
						i_q <= i_q + CNT_W'(1);
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
					k_q <= k_q + CNT_W'(1);
					state_q <= (k_q == CNT_W'(e_q)) ? S_POP : S_MRG_RD;
				end
				S_EMIT_RD: state_q <= S_EMIT_LD;
				// Present one record and hold it until its transfer.
				S_EMIT_LD: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
						if ((k_q + CNT_W'(1)) == cnt_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + CNT_W'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	`RMSN_ASSERT(a_no_load_while_emit, !(in_ready && out_valid_q), "input taken while emitting")
	`RMSN_ASSERT(a_stack_bound, sp_q <= SP_W'(STK_D), "range stack overflow")
	`RMSN_ASSERT(a_count_bound, cnt_q <= CNT_W'(MAX_RECORDS), "record count beyond capacity")
	`RMSN_ASSERT(a_merge_range, (state_q != S_MRG_WR) || (k_q <= CNT_W'(e_q)), "merge past range")

endmodule

@@ hw/rtl/record_merge_sort_by_name_top.sv @@
// ----------------------------------------------------------------------------
// record_merge_sort_by_name_top
// Loads name/age records and emits them sorted by name (top-down merge sort).
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// input    in         in_valid/in_ready    name_bytes_*, age_value, last_record
// output   out        out_valid/out_ready  sorted_bytes_*, sorted_age, final_output, overflow
//
// Loading accepts one record per cycle; input is refused while a set is sorted or emitted.
// Each merge of a range copies it into scratch and then merges it back, both through the
// registered store and scratch ports, after a walk of the split tree; each emitted record
// is read from the store, loaded into the output register and then presented.
// Reset clears the controller only; the record memories are not cleared.
// An output stall holds the emitted record in the output register.
module record_merge_sort_by_name_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] name_bytes_0_7,
	input  logic [63:0] name_bytes_8_15,
	input  logic [31:0] name_bytes_16_19,
	input  logic [7:0]  age_value,
	input  logic        last_record,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] sorted_bytes_0_7,
	output logic [63:0] sorted_bytes_8_15,
	output logic [31:0] sorted_bytes_16_19,
	output logic [7:0]  sorted_age,
	output logic        final_output,
	output logic        overflow
);
	import rmsn_pkg::*;

	cmd_t cmd;
	sts_t sts;
	rec_t in_rec;
	rec_t out_rec;

	assign in_rec = '{hi: name_bytes_0_7, mid: name_bytes_8_15, lo: name_bytes_16_19,
		age: age_value};

	// Controller.
	rmsn_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_record(last_record),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Datapath.
	rmsn_datapath u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.in_rec   (in_rec),
		.sts      (sts),
		.out_rec  (out_rec),
		.out_final(final_output),
		.out_ovf  (overflow)
	);

	assign sorted_bytes_0_7   = out_rec.hi;
	assign sorted_bytes_8_15  = out_rec.mid;
	assign sorted_bytes_16_19 = out_rec.lo;
	assign sorted_age         = out_rec.age;

endmodule

@@ tb/sv/tb_record_merge_sort_by_name_top.sv @@
// ----------------------------------------------------------------------------
// tb_record_merge_sort_by_name_top
// Self-checking bench for the record merge sorter: loads record sets, predicts
// the merge-sorted output order (including the order of equal names and the
// overflow flag), and compares every emitted record in order.
// ----------------------------------------------------------------------------
module tb_record_merge_sort_by_name_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rmsn_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] name_bytes_0_7;
	logic [63:0] name_bytes_8_15;
	logic [31:0] name_bytes_16_19;
	logic [7:0]  age_value;
	logic        last_record;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] sorted_bytes_0_7;
	logic [63:0] sorted_bytes_8_15;
	logic [31:0] sorted_bytes_16_19;
	logic [7:0]  sorted_age;
	logic        final_output;
	logic        overflow;

	// One emitted record as predicted.
	typedef struct packed {
		rec_t rec;
		logic fin;
		logic ovf;
	} sorted_rec_t;

	rec_t        loaded_set[$];
	logic        set_dropped;
	sorted_rec_t sorted_due[$];
	int          error_count;
	int          idle_cycles;
	bit          idle_in_on;
	bit          idle_out_on;

	record_merge_sort_by_name_top i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.name_bytes_0_7     (name_bytes_0_7),
		.name_bytes_8_15    (name_bytes_8_15),
		.name_bytes_16_19   (name_bytes_16_19),
		.age_value          (age_value),
		.last_record        (last_record),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.sorted_bytes_0_7   (sorted_bytes_0_7),
		.sorted_bytes_8_15  (sorted_bytes_8_15),
		.sorted_bytes_16_19 (sorted_bytes_16_19),
		.sorted_age         (sorted_age),
		.final_output       (final_output),
		.overflow           (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Name order as strcmp sees it over the 20 characters.
	function automatic bit name_less(rec_t a, rec_t b);
		logic [159:0] na;
		logic [159:0] nb;
		logic [7:0]   ca;
		logic [7:0]   cb;
		na = {a.hi, a.mid, a.lo};
		nb = {b.hi, b.mid, b.lo};
		for (int k = 0; k < 20; k++) begin
			ca = na[159 - 8*k -: 8];
			cb = nb[159 - 8*k -: 8];
			if (ca != cb) return ca < cb;
			if (ca == 8'd0) return 1'b0;
		end
		return 1'b0;
	endfunction

	// Top-down merge sort over [lo_i, hi_i]; equal names take the right side first.
	function automatic void merge_sort(ref rec_t recs[$], input int lo_i, input int hi_i);
		rec_t tmp[$];
		int   mid_i;
		int   i;
		int   j;
		if (lo_i >= hi_i) return;
		mid_i = (lo_i + hi_i) / 2;
		merge_sort(recs, lo_i, mid_i);
		merge_sort(recs, mid_i + 1, hi_i);
		i = lo_i;
		j = mid_i + 1;
		while (i <= mid_i && j <= hi_i) begin
			if (name_less(recs[i], recs[j])) tmp.push_back(recs[i++]);
			else tmp.push_back(recs[j++]);
		end
		while (i <= mid_i) tmp.push_back(recs[i++]);
		while (j <= hi_i) tmp.push_back(recs[j++]);
		for (int k = 0; k < tmp.size(); k++) recs[lo_i + k] = tmp[k];
	endfunction

	// Store one accepted record; on the last one, queue the sorted run.
	function automatic void predict_sorted_run(rec_t r, bit last);
		sorted_rec_t s;
		if (loaded_set.size() < MAX_RECORDS) loaded_set.push_back(r);
		else set_dropped = 1'b1;
		if (!last) return;
		merge_sort(loaded_set, 0, loaded_set.size() - 1);
		foreach (loaded_set[k]) begin
			s.rec = loaded_set[k];
			s.fin = (k == loaded_set.size() - 1);
			s.ovf = set_dropped;
			sorted_due.push_back(s);
		end
		loaded_set.delete();
		set_dropped = 1'b0;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h, expected %h", what, got, want);
		error_count++;
	endtask

	// Send one record and hold it until the transfer.
	task automatic send_record(logic [63:0] hi, logic [63:0] mid, logic [31:0] lo,
			logic [7:0] age, bit last);
		rec_t r;
		if (idle_in_on) begin
			while ($urandom_range(99) < 22) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid         <= 1'b1;
		name_bytes_0_7   <= hi;
		name_bytes_8_15  <= mid;
		name_bytes_16_19 <= lo;
		age_value        <= age;
		last_record      <= last;
		do @(posedge clk); while (!in_ready);
		r = '{hi: hi, mid: mid, lo: lo, age: age};
		predict_sorted_run(r, last);
		@(negedge clk);
	endtask

	// Random name: mostly strings over a three-letter alphabet so equal names occur often.
	task automatic send_random_record(bit last);
		logic [159:0] nm;
		int           len;
		nm  = {$urandom, $urandom, $urandom, $urandom, $urandom};
		len = $urandom_range(20);
		if ($urandom_range(99) < 80) begin
			for (int k = 0; k < 20; k++) begin
				if (k < len) nm[159 - 8*k -: 8] = 8'h41 + 8'($urandom_range(2));
				else if (k == len || $urandom_range(1)) nm[159 - 8*k -: 8] = 8'h00;
			end
		end
		send_record(nm[159:96], nm[95:32], nm[31:0], 8'($urandom), last);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sorted_due.size() != 0) @(negedge clk);
	endtask

	task automatic test_extremes();
		send_record('1, '1, '1, 8'hFF, 1'b0);
		send_record('0, '0, '0, 8'h00, 1'b0);
		send_record(64'h8000_0000_0000_0000, '0, '0, 8'h80, 1'b0);
		send_record(64'h7F00_0000_0000_0000, '1, '1, 8'h7F, 1'b0);
		send_record(64'h4142_4300_FFFF_FFFF, '1, '1, 8'h01, 1'b0);
		send_record(64'h4142_4300_0000_0000, '0, '0, 8'h02, 1'b0);
		send_record('1, '1, 32'hFFFF_FFFE, 8'h03, 1'b1);
		send_record(64'h4100_0000_0000_0000, '0, '0, 8'h05, 1'b1);
		wait_drained();
	endtask

	task automatic test_equal_names();
		for (int k = 0; k < 7; k++)
			send_record(64'h4242_0000_0000_0000, '0, '0, 8'(k), k == 6);
		wait_drained();
	endtask

	// Overflowing sets run without idling on either side.
	task automatic test_overflow();
		idle_in_on  = 1'b0;
		idle_out_on = 1'b0;
		for (int k = 0; k < MAX_RECORDS + 2; k++) send_random_record(k == MAX_RECORDS + 1);
		wait_drained();
		for (int k = 0; k < MAX_RECORDS + 1; k++) send_random_record(k == MAX_RECORDS);
		wait_drained();
		idle_in_on  = 1'b1;
		idle_out_on = 1'b1;
	endtask

	task automatic test_random_sets();
		int sent;
		int n;
		sent = 0;
		while (sent < 20) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(33) + 1 : $urandom_range(8) + 1;
			for (int k = 0; k < n; k++) send_random_record(k == n - 1);
			sent += n;
		end
		wait_drained();
	endtask

	// Receiver: random stalls, field-by-field comparison against the oldest expectation.
	always @(negedge clk) begin
		out_ready <= arst_n && !(idle_out_on && $urandom_range(99) < 22);
	end

	always @(posedge clk) begin
		sorted_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (sorted_due.size() == 0) begin
				$display("MISMATCH unexpected transfer of sorted record");
				error_count++;
			end else begin
				want = sorted_due.pop_front();
				if (sorted_bytes_0_7 !== want.rec.hi)
					report_mismatch("sorted_bytes_0_7", sorted_bytes_0_7, want.rec.hi);
				if (sorted_bytes_8_15 !== want.rec.mid)
					report_mismatch("sorted_bytes_8_15", sorted_bytes_8_15, want.rec.mid);
				if (sorted_bytes_16_19 !== want.rec.lo)
					report_mismatch("sorted_bytes_16_19", 64'(sorted_bytes_16_19),
						64'(want.rec.lo));
				if (sorted_age !== want.rec.age)
					report_mismatch("sorted_age", 64'(sorted_age), 64'(want.rec.age));
				if (final_output !== want.fin)
					report_mismatch("final_output", 64'(final_output), 64'(want.fin));
				if (overflow !== want.ovf)
					report_mismatch("overflow", 64'(overflow), 64'(want.ovf));
			end
		end
	end

	// Watchdog: cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		out_ready        = 1'b0;
		name_bytes_0_7   = '0;
		name_bytes_8_15  = '0;
		name_bytes_16_19 = '0;
		age_value        = '0;
		last_record      = 1'b0;
		error_count      = 0;
		idle_cycles      = 0;
		set_dropped      = 1'b0;
		idle_in_on       = 1'b1;
		idle_out_on      = 1'b1;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_equal_names();
		test_overflow();
		test_random_sets();
		repeat (50) @(negedge clk);
		if (error_count == 0 && sorted_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
